/* rtl/core/lds_pkg.sv */
// Shared types and codes for the LOOK disk scheduler.
`timescale 1ns / 1ps

package lds_pkg;

    localparam int LDS_DEPTH = 16;
    localparam int TRACK_W   = 10;
    localparam int SECTOR_W  = 8;
    localparam int TAG_W     = 8;
    localparam int STATUS_W  = 2;

    // request function codes
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture request and run the per-cell compares
        logic update;  // commit store/pointer update and load the response register
    } t_cmd;

endpackage

/* rtl/core/lds_if.sv */
// Request and response channel interfaces for the LOOK disk scheduler.
`timescale 1ns / 1ps

interface lds_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [9:0] track;
    logic [7:0] sector;
    logic [7:0] request_tag;

    modport source (output valid, output func, output track, output sector,
                    output request_tag, input ready);
    modport sink   (input valid, input func, input track, input sector,
                    input request_tag, output ready);
endinterface

interface lds_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] served_track;
    logic [7:0] served_sector;
    logic [7:0] served_tag;
    logic       turned;
    logic       sweeping_up;

    modport source (output valid, output status, output served_track,
                    output served_sector, output served_tag, output turned,
                    output sweeping_up, input ready);
    modport sink   (input valid, input status, input served_track,
                    input served_sector, input served_tag, input turned,
                    input sweeping_up, output ready);
endinterface

/* rtl/core/look_disk_scheduler.sv */
// Top level of the LOOK (elevator) disk request scheduler.
`timescale 1ns / 1ps

// Usage
//   i_req : request channel. func 0 inserts (track, sector, request_tag) into
//           the sorted pending store; func 1 removes the next request to serve.
//   o_rsp : one response per request: status (ok / full / empty), the served
//           entry on a remove (zero otherwise), turned, sweeping_up.
// Steps
//   A request is captured at the accept edge together with one track compare
//   per store cell, run in parallel; the update step then commits the shift of
//   the cells and loads the response register, once that register is free. One
//   request is in flight at a time, so a new request is accepted only after the
//   last one has been committed. The store is a row of DEPTH shift cells.
// Stall
//   A response waits in its register while o_rsp.ready is low; the next request
//   is still accepted and held in the commit step until the register frees.
// Reset
//   Synchronous, active low: store empty, sweep upward, current position at
//   the first cell, no response pending. No clearing pass.

module look_disk_scheduler #(
    parameter int DEPTH = lds_pkg::LDS_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lds_req_if.sink    i_req,
    lds_rsp_if.source  o_rsp
);
    import lds_pkg::*;

    t_cmd   cmd;
    t_entry served;

    lds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lds_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_req.func),
        .i_track       (i_req.track),
        .i_sector      (i_req.sector),
        .i_tag         (i_req.request_tag),
        .o_status      (o_rsp.status),
        .o_served      (served),
        .o_turned      (o_rsp.turned),
        .o_sweeping_up (o_rsp.sweeping_up)
    );

    assign o_rsp.served_track  = served.track;
    assign o_rsp.served_sector = served.sector;
    assign o_rsp.served_tag    = served.tag;

endmodule

/* rtl/core/lds_ctrl.sv */
// Controller state machine of the LOOK disk scheduler.
`timescale 1ns / 1ps

module lds_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output lds_pkg::t_cmd o_cmd
);
    import lds_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.update = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_UPD;
            end
            S_UPD: begin
                if (o_cmd.update) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // response register: set on update, drained when taken
        if (o_cmd.update)     n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/lds_datapath.sv */
// Sorted shift-cell store, sweep pointer and response register.
`timescale 1ns / 1ps

module lds_datapath #(
    parameter int DEPTH = lds_pkg::LDS_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lds_pkg::t_cmd                 i_cmd,
    input  logic                          i_func,
    input  logic [lds_pkg::TRACK_W-1:0]   i_track,
    input  logic [lds_pkg::SECTOR_W-1:0]  i_sector,
    input  logic [lds_pkg::TAG_W-1:0]     i_tag,
    output logic [lds_pkg::STATUS_W-1:0]  o_status,
    output lds_pkg::t_entry               o_served,
    output logic                          o_turned,
    output logic                          o_sweeping_up
);
    import lds_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry               r_cell [DEPTH];
    t_entry               n_cell [DEPTH];
    logic [DEPTH-1:0]     r_lt;         // cell holds a live entry below the new track
    logic                 r_func;
    t_entry               r_new;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic                 r_dir_up, n_dir_up;

    logic [STATUS_W-1:0]  r_status, n_status;
    t_entry               r_served, n_served;
    logic                 r_turned, n_turned;
    logic                 r_up;

    t_entry               sel;
    logic                 has_next;

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_cur    = r_cur;
        n_dir_up = r_dir_up;
        n_status = ST_OK;
        n_served = '0;
        n_turned = 1'b0;

        // current entry, one-hot pick over the cells
        sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) == r_cur) sel = r_cell[i];
        end
        has_next = r_dir_up ? ((CNT_W'(r_cur) + CNT_W'(1)) < r_count)
                            : (r_cur != '0);

        if (r_func == FN_INSERT) begin
            if (r_count == CNT_W'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                // lt is a thermometer: keep below, drop new at the edge, shift above
                if (!r_lt[0]) n_cell[0] = r_new;
                for (int i = 1; i < DEPTH; i++) begin
                    if (!r_lt[i]) n_cell[i] = r_lt[i-1] ? r_new : r_cell[i-1];
                end
                if (r_count == '0)      n_cur = '0;
                else if (!r_lt[r_cur])  n_cur = r_cur + IDX_W'(1);
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_served = sel;
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (IDX_W'(i) >= r_cur) n_cell[i] = r_cell[i+1];
                end
                n_count = r_count - CNT_W'(1);
                if (has_next) begin
                    n_cur = r_dir_up ? r_cur : r_cur - IDX_W'(1);
                end else begin
                    n_turned = 1'b1;
                    n_dir_up = !r_dir_up;
                    if (!r_dir_up)                n_cur = '0;
                    else if (r_count >= CNT_W'(2)) n_cur = IDX_W'(r_count - CNT_W'(2));
                    else                           n_cur = '0;
                end
            end
        end
    end

    // payload, cells and response fields: no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_new  <= '{track: i_track, sector: i_sector, tag: i_tag};
            for (int i = 0; i < DEPTH; i++) begin
                r_lt[i] <= (CNT_W'(i) < r_count) && (r_cell[i].track < i_track);
            end
        end
        if (i_cmd.update) begin
            r_cell   <= n_cell;
            r_status <= n_status;
            r_served <= n_served;
            r_turned <= n_turned;
            r_up     <= n_dir_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cur    <= '0;
            r_dir_up <= 1'b1;
        end else if (i_cmd.update) begin
            r_count  <= n_count;
            r_cur    <= n_cur;
            r_dir_up <= n_dir_up;
        end
    end

    assign o_status      = r_status;
    assign o_served      = r_served;
    assign o_turned      = r_turned;
    assign o_sweeping_up = r_up;

endmodule

/* rtl/core/lds_checker.sv */
// Port-level checks for the LOOK disk scheduler, bound to the top level.
`timescale 1ns / 1ps

module lds_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [9:0] i_served_track,
    input logic [7:0] i_served_sector,
    input logic [7:0] i_served_tag,
    input logic       i_turned
);
    import lds_pkg::*;

    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_served_track) && $stable(i_turned))
        else $error("response changed while stalled");

    // one request in flight
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // failed requests carry no served entry
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL || i_status == ST_EMPTY) |->
            i_served_track == '0 && i_served_sector == '0
            && i_served_tag == '0 && !i_turned)
        else $error("served fields set on failed request");

    // a turn only happens on a served remove
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_turned |-> i_status == ST_OK)
        else $error("turn flagged on failed request");

    // nothing pending straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

endmodule

bind look_disk_scheduler lds_checker u_lds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_served_track  (o_rsp.served_track),
    .i_served_sector (o_rsp.served_sector),
    .i_served_tag    (o_rsp.served_tag),
    .i_turned        (o_rsp.turned)
);
